// File: hdl/tte_pkg.sv
`timescale 1ns / 1ps

package tte_pkg;

	localparam int INDEX_BITS_DEF = 12;

	// Operation codes carried by func.
	localparam logic [1:0] FUNC_PROBE  = 2'd0;
	localparam logic [1:0] FUNC_RECORD = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// Bound kinds carried by bound_kind.
	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;
	localparam logic [1:0] BOUND_NONE  = 2'd3;

	// Slot occupancy codes held in the table.
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_EXACT = 2'd1;
	localparam logic [1:0] KIND_UPPER = 2'd2;
	localparam logic [1:0] KIND_LOWER = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [63:0]        position_key;
		logic [5:0]         search_depth;
		logic signed [31:0] score_value;
		logic [1:0]         bound_kind;
		logic signed [31:0] alpha_bound;
		logic signed [31:0] beta_bound;
	} item_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] result_score;
		logic               written;
	} result_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [63:0]        key;
		logic signed [31:0] score;
		logic [5:0]         depth;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the item and start the slot read
		logic finish;   // evaluate, write back and load the output register
		logic sweep_wr; // empty one slot of the clearing sweep
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;   // the held item is a clear
		logic out_busy;   // the output register holds a result not yet taken
		logic sweep_last; // the sweep is at its final slot
	} status_t;

endpackage

// File: hdl/tte_in_if.sv
`timescale 1ns / 1ps

interface tte_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [63:0]        position_key;
	logic [5:0]         search_depth;
	logic signed [31:0] score_value;
	logic [1:0]         bound_kind;
	logic signed [31:0] alpha_bound;
	logic signed [31:0] beta_bound;

	modport source (
		output valid, func, position_key, search_depth, score_value, bound_kind,
			alpha_bound, beta_bound,
		input ready
	);
	modport sink (
		input valid, func, position_key, search_depth, score_value, bound_kind,
			alpha_bound, beta_bound,
		output ready
	);
endinterface

// File: hdl/tte_out_if.sv
`timescale 1ns / 1ps

interface tte_out_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] result_score;
	logic               written;

	modport source (output valid, hit, result_score, written, input ready);
	modport sink (input valid, hit, result_score, written, output ready);
endinterface

// File: hdl/tte_ctrl.sv
`timescale 1ns / 1ps

module tte_ctrl
	import tte_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_LOOK
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && ready_q;
		cmd.finish   = (state_q == S_LOOK) && !st.out_busy;
		cmd.sweep_wr = (state_q == S_SWEEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_SWEEP: begin
					if (st.sweep_last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= S_LOOK;
						ready_q <= 1'b0;
					end
				end
				S_LOOK: begin
					if (!st.out_busy) begin
						if (st.is_clear) begin
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_SWEEP;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: hdl/tte_datapath.sv
`timescale 1ns / 1ps

module tte_datapath
	import tte_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output status_t st,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t result
);

	localparam int SLOTS = 1 << INDEX_BITS;

	slot_t                  mem [SLOTS];
	slot_t                  rd_q;
	item_t                  item_q;
	logic [INDEX_BITS-1:0]  sweep_q;
	logic                   out_valid_q;
	result_t                result_q;

	logic                   wr_en;
	logic [INDEX_BITS-1:0]  wr_addr;
	slot_t                  wr_word;
	logic                   occupied;
	logic                   usable;
	logic                   rec_ok;
	result_t                res;

	always_comb begin
		occupied = (rd_q.kind != KIND_EMPTY);
		usable   = occupied && (rd_q.key == item_q.position_key)
			&& (rd_q.depth >= item_q.search_depth);
		rec_ok   = (item_q.func == FUNC_RECORD) && (item_q.bound_kind != BOUND_NONE)
			&& !(occupied && (rd_q.depth > item_q.search_depth));

		res = '0;
		if (item_q.func == FUNC_PROBE && usable) begin
			case (rd_q.kind)
				KIND_EXACT: begin
					res.hit          = 1'b1;
					res.result_score = rd_q.score;
				end
				KIND_UPPER: begin
					if (rd_q.score <= item_q.alpha_bound) begin
						res.hit          = 1'b1;
						res.result_score = item_q.alpha_bound;
					end
				end
				KIND_LOWER: begin
					if (rd_q.score >= item_q.beta_bound) begin
						res.hit          = 1'b1;
						res.result_score = item_q.beta_bound;
					end
				end
				default: res.hit = 1'b0;
			endcase
		end
		res.written = rec_ok;

		if (cmd.sweep_wr) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_word = '0;
		end else begin
			wr_en         = cmd.finish && rec_ok;
			wr_addr       = item_q.position_key[INDEX_BITS-1:0];
			wr_word.kind  = item_q.bound_kind + 2'd1;
			wr_word.key   = item_q.position_key;
			wr_word.score = item_q.score_value;
			wr_word.depth = item_q.search_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (cmd.load) begin
			rd_q   <= mem[item.position_key[INDEX_BITS-1:0]];
			item_q <= item;
		end
		if (cmd.finish) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_wr) begin
				sweep_q <= sweep_q + INDEX_BITS'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.is_clear   = (item_q.func == FUNC_CLEAR);
	assign st.out_busy   = out_valid_q && !out_ready;
	assign st.sweep_last = &sweep_q;
	assign out_valid     = out_valid_q;
	assign result        = result_q;

endmodule

// File: hdl/transposition_table_engine.sv
`timescale 1ns / 1ps

// Direct-mapped transposition table with depth-preferred replacement. Each item
// is a probe, a record, a clear or the unnamed fourth code, and each gives
// exactly one result item. The table holds 2**INDEX_BITS slots in a single-port
// synchronous memory; the slot is chosen by the low INDEX_BITS bits of the
// position key. An item is accepted in the idle state, which starts the
// registered memory read, and then moves to the look-up state, which waits
// for a free output register, evaluates the slot, writes it back and loads the
// output register. The block works on one item at a time and accepts the next
// one as soon as the result has gone into the output register. A clear starts
// a sweep that empties one slot per cycle; no item is accepted until it ends,
// and the same sweep runs after reset before the first item is accepted.
module transposition_table_engine
	import tte_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tte_in_if.sink    in_ch,
	tte_out_if.source out_ch
);

	cmd_t    cmd;
	status_t st;
	item_t   item;
	result_t result;
	logic    in_ready;
	logic    out_valid;

	// Gather the incoming item into one word for the datapath.
	always_comb begin
		item.func         = in_ch.func;
		item.position_key = in_ch.position_key;
		item.search_depth = in_ch.search_depth;
		item.score_value  = in_ch.score_value;
		item.bound_kind   = in_ch.bound_kind;
		item.alpha_bound  = in_ch.alpha_bound;
		item.beta_bound   = in_ch.beta_bound;
	end

	assign in_ch.ready = in_ready;

	// The sequencer: clearing sweep, waiting for an item, slot look-up.
	tte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The table memory, the held item, the evaluation and the output register.
	tte_datapath #(
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.st        (st),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign out_ch.valid        = out_valid;
	assign out_ch.hit          = result.hit;
	assign out_ch.result_score = result.result_score;
	assign out_ch.written      = result.written;

`ifndef SYNTHESIS
	// Only one item is ever in flight: ready drops straight after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
	else $error("second item accepted while one is in flight");

	// A result is never loaded over one that has not yet been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_ch.valid && !out_ch.ready))
	else $error("output register overwritten");

	// A result without a hit carries a zero score.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.hit |-> out_ch.result_score == 32'sd0)
	else $error("non-zero score without a hit");

	// A hit comes from a probe only, so it never goes with a write.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.hit |-> !out_ch.written)
	else $error("hit and written both set");
`endif

endmodule

// File: sim/tte_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the transposition table, keeps its own copy of the
// table and compares every result item with the one it predicts.
module tte_checker
	import tte_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tte_in_if    in_ch,
	tte_out_if   out_ch,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output int   probe_hits,
	output int   records_written
);

	localparam int SLOTS = 1 << INDEX_BITS;
	localparam int REPORT_LIMIT = 10;

	slot_t   slot_table [SLOTS];
	result_t awaited_results [$];

	// Applies one item to the shadow table and returns the result it gives.
	function automatic result_t table_outcome(input item_t it);
		logic [INDEX_BITS-1:0] idx;
		slot_t                 s;
		result_t               r;
		logic [1:0]            new_kind;
		idx = it.position_key[INDEX_BITS-1:0];
		s = slot_table[idx];
		r = '0;
		case (it.func)
			FUNC_PROBE: begin
				if (s.kind != KIND_EMPTY && s.key == it.position_key &&
						s.depth >= it.search_depth) begin
					if (s.kind == KIND_EXACT) begin
						r.hit = 1'b1;
						r.result_score = s.score;
					end else if (s.kind == KIND_UPPER &&
							$signed(s.score) <= $signed(it.alpha_bound)) begin
						r.hit = 1'b1;
						r.result_score = it.alpha_bound;
					end else if (s.kind == KIND_LOWER &&
							$signed(s.score) >= $signed(it.beta_bound)) begin
						r.hit = 1'b1;
						r.result_score = it.beta_bound;
					end
				end
			end
			FUNC_RECORD: begin
				// Depth-preferred: only a strictly deeper occupant refuses the write.
				if (it.bound_kind != BOUND_NONE &&
						!(s.kind != KIND_EMPTY && s.depth > it.search_depth)) begin
					case (it.bound_kind)
						BOUND_EXACT: new_kind = KIND_EXACT;
						BOUND_UPPER: new_kind = KIND_UPPER;
						default:     new_kind = KIND_LOWER;
					endcase
					slot_table[idx] = '{kind: new_kind, key: it.position_key,
						score: it.score_value, depth: it.search_depth};
					r.written = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				foreach (slot_table[i])
					slot_table[i].kind = KIND_EMPTY;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		if (fail_count < REPORT_LIMIT)
			$display("tte_checker: %s", msg);
		fail_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t want;
		result_t got;
		result_t predicted;
		if (!arst_n) begin
			awaited_results.delete();
			foreach (slot_table[i])
				slot_table[i] = '0;
			pending <= 0;
			results_seen <= 0;
			probe_hits <= 0;
			records_written <= 0;
		end else begin
			// Results are taken before new items so that a result can never be
			// matched against the item accepted at the same edge.
			if (out_ch.valid && out_ch.ready) begin
				got.hit = out_ch.hit;
				got.result_score = out_ch.result_score;
				got.written = out_ch.written;
				results_seen <= results_seen + 1;
				if (got.hit === 1'b1)
					probe_hits <= probe_hits + 1;
				if (got.written === 1'b1)
					records_written <= records_written + 1;
				if (awaited_results.size() == 0) begin
					note_failure($sformatf("unexpected result hit=%0b score=%0d written=%0b",
						got.hit, got.result_score, got.written));
				end else begin
					want = awaited_results.pop_front();
					if (want.hit !== got.hit || want.result_score !== got.result_score ||
							want.written !== got.written)
						note_failure($sformatf(
							"mismatch: expected hit=%0b score=%0d written=%0b, got hit=%0b score=%0d written=%0b",
							want.hit, want.result_score, want.written,
							got.hit, got.result_score, got.written));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				it.func = in_ch.func;
				it.position_key = in_ch.position_key;
				it.search_depth = in_ch.search_depth;
				it.score_value = in_ch.score_value;
				it.bound_kind = in_ch.bound_kind;
				it.alpha_bound = in_ch.alpha_bound;
				it.beta_bound = in_ch.beta_bound;
				predicted = table_outcome(it);
				awaited_results = {awaited_results, predicted};
			end
			pending <= awaited_results.size();
		end
	end

endmodule

// File: sim/tb_transposition_table_engine.sv
`timescale 1ns / 1ps

// Testbench for the transposition table engine. This module only makes stimulus
// and gives the verdict; the checker beside the block keeps a shadow table,
// predicts each result item and counts every disagreement.
//
// The stimulus opens with a short directed run over the corner cases: empty
// slots, the extreme keys and scores, equality at both window edges, depth
// refusal, replacement by a different key in the same slot, the unused bound
// kind, the unused operation and a clear. The random part then draws most keys
// from a small pool that aliases several keys onto few slots, so records and
// probes keep meeting each other and hits, refusals and key mismatches are all
// common. Idling is varied phase by phase on both sides.
module tb_transposition_table_engine;
	import tte_pkg::*;

	localparam int POOL_SIZE = 24;
	localparam int POOL_SLOTS = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	// The one operation code the package leaves unnamed; the block must ignore it.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
	localparam logic [63:0] KEY_ZERO = 64'h0;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	// Same slot as KEY_ONES, but differs in the top bit.
	localparam logic [63:0] KEY_ALIAS = 64'h7FFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;

	tte_in_if  in_ch ();
	tte_out_if out_ch ();

	int fail_count;
	int pending;
	int results_seen;
	int probe_hits;
	int records_written;

	// Idling controls, written by the stimulus process and read by the drivers.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_count = 0;

	int items_sent = 0;
	int clears_sent = 0;
	logic [63:0] key_pool [POOL_SIZE];

	transposition_table_engine #(
		.INDEX_BITS(INDEX_BITS_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	tte_checker #(
		.INDEX_BITS(INDEX_BITS_DEF)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.probe_hits(probe_hits),
		.records_written(records_written)
	);

	always #2 clk = ~clk;

	// Result side. Normally ready is drawn at random each cycle; when a long
	// hold is requested it stays low until the hold counted here reaches its
	// limit, so that the block fills up and has to refuse new items.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				out_ch.ready <= 1'b0;
				hold_count++;
				if (hold_count >= HOLD_CYCLES)
					hold_done = 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// A hung block must not hang the run.
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic item_t make_item(input logic [1:0] f, input logic [63:0] k,
			input logic [5:0] d, input logic signed [31:0] s, input logic [1:0] b,
			input logic signed [31:0] a, input logic signed [31:0] bt);
		item_t it;
		it.func = f;
		it.position_key = k;
		it.search_depth = d;
		it.score_value = s;
		it.bound_kind = b;
		it.alpha_bound = a;
		it.beta_bound = bt;
		return it;
	endfunction

	// Half of the scores and window edges lie close to zero, so that the bound
	// comparisons fall either way and sometimes meet exactly; the rest span the
	// whole signed range.
	function automatic logic signed [31:0] random_score();
		if ($urandom_range(1) == 0)
			return $urandom();
		return $signed($urandom_range(100)) - 50;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    pick;
		pick = $urandom_range(999);
		if (pick < 12)
			it.func = FUNC_CLEAR;
		else if (pick < 40)
			it.func = FUNC_UNUSED;
		else if (pick < 520)
			it.func = FUNC_PROBE;
		else
			it.func = FUNC_RECORD;
		// Mostly pooled keys so that probes find what records stored; now and
		// then a fresh key, which almost always misses or evicts.
		if ($urandom_range(9) == 0)
			it.position_key = {$urandom(), $urandom()};
		else
			it.position_key = key_pool[$urandom_range(POOL_SIZE - 1)];
		// Shallow depths dominate so that the depth test goes both ways often.
		if ($urandom_range(3) == 0)
			it.search_depth = 6'($urandom_range(63));
		else
			it.search_depth = 6'($urandom_range(7));
		it.score_value = random_score();
		if ($urandom_range(11) == 0) begin
			it.bound_kind = BOUND_NONE;
		end else begin
			case ($urandom_range(2))
				0:       it.bound_kind = BOUND_EXACT;
				1:       it.bound_kind = BOUND_UPPER;
				default: it.bound_kind = BOUND_LOWER;
			endcase
		end
		it.alpha_bound = random_score();
		it.beta_bound = random_score();
		return it;
	endfunction

	// Offers one item and returns at the edge where it is accepted. Valid is
	// left high afterwards, so back-to-back items need no extra assignment.
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= it.func;
		in_ch.position_key <= it.position_key;
		in_ch.search_depth <= it.search_depth;
		in_ch.score_value <= it.score_value;
		in_ch.bound_kind <= it.bound_kind;
		in_ch.alpha_bound <= it.alpha_bound;
		in_ch.beta_bound <= it.beta_bound;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
		if (it.func == FUNC_CLEAR)
			clears_sent++;
	endtask

	task automatic send_random(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count)
			send_item(random_item());
	endtask

	// The sender stops and waits until every expected result has come back.
	// The first edge is always taken so that the item just accepted is counted.
	task automatic wait_until_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_PROBE;
		in_ch.position_key = '0;
		in_ch.search_depth = '0;
		in_ch.score_value = '0;
		in_ch.bound_kind = BOUND_EXACT;
		in_ch.alpha_bound = '0;
		in_ch.beta_bound = '0;
		arst_n = 1'b0;

		// Six pooled keys sit at the two extreme slots and the others share six random
		// slots, three keys to every slot, differing only above the index bits.
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = {$urandom(), $urandom()};
			case (i % POOL_SLOTS)
				0:       key_pool[i][INDEX_BITS_DEF-1:0] = '0;
				1:       key_pool[i][INDEX_BITS_DEF-1:0] = '1;
				default: key_pool[i][INDEX_BITS_DEF-1:0] = key_pool[i % POOL_SLOTS][INDEX_BITS_DEF-1:0];
			endcase
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, without idling. The block clears its table after
		// reset; the first item simply waits for ready.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// A probe of an empty slot misses.
		send_item(make_item(FUNC_PROBE, KEY_ZERO, 6'd0, '0, BOUND_EXACT, '0, '0));
		// An exact entry at depth 0 with the most negative score.
		send_item(make_item(FUNC_RECORD, KEY_ZERO, 6'd0, SCORE_MIN, BOUND_EXACT, '0, '0));
		send_item(make_item(FUNC_PROBE, KEY_ZERO, 6'd0, '0, BOUND_EXACT, SCORE_MAX, SCORE_MIN));
		// Asking for more depth than is stored misses.
		send_item(make_item(FUNC_PROBE, KEY_ZERO, 6'd1, '0, BOUND_EXACT, '0, '0));
		// An upper bound at the deepest depth in the last slot.
		send_item(make_item(FUNC_RECORD, KEY_ONES, 6'd63, 32'sd100, BOUND_UPPER,
			SCORE_MAX, SCORE_MAX));
		// Upper bound equal to alpha hits and returns alpha; one below misses.
		send_item(make_item(FUNC_PROBE, KEY_ONES, 6'd63, '0, BOUND_EXACT, 32'sd100, SCORE_MIN));
		send_item(make_item(FUNC_PROBE, KEY_ONES, 6'd63, '0, BOUND_EXACT, 32'sd99, SCORE_MIN));
		// A shallower record is refused by the deeper occupant.
		send_item(make_item(FUNC_RECORD, KEY_ONES, 6'd62, SCORE_MAX, BOUND_LOWER, '0, '0));
		// Equal depth replaces, whatever key the slot held.
		send_item(make_item(FUNC_RECORD, KEY_ALIAS, 6'd63, SCORE_MAX, BOUND_LOWER, '0, '0));
		// The key bits above the index are compared: the old key now misses.
		send_item(make_item(FUNC_PROBE, KEY_ONES, 6'd0, '0, BOUND_EXACT, SCORE_MIN, SCORE_MIN));
		// Lower bound equal to beta hits and returns beta, also the extreme beta.
		send_item(make_item(FUNC_PROBE, KEY_ALIAS, 6'd0, '0, BOUND_EXACT, SCORE_MIN, SCORE_MAX));
		send_item(make_item(FUNC_PROBE, KEY_ALIAS, 6'd63, '0, BOUND_EXACT, SCORE_MAX, SCORE_MIN));
		// An upper bound above alpha gives no score.
		send_item(make_item(FUNC_RECORD, 64'h5, 6'd2, 32'sd10, BOUND_UPPER, '0, '0));
		send_item(make_item(FUNC_PROBE, 64'h5, 6'd2, '0, BOUND_EXACT, 32'sd9, SCORE_MAX));
		// The unused bound kind is ignored, and so is the unused operation.
		send_item(make_item(FUNC_RECORD, 64'h6, 6'd5, 32'sd7, BOUND_NONE, '0, '0));
		send_item(make_item(FUNC_PROBE, 64'h6, 6'd0, '0, BOUND_EXACT, SCORE_MIN, SCORE_MAX));
		send_item(make_item(FUNC_UNUSED, KEY_ONES, 6'd63, -32'sd1, BOUND_NONE, -32'sd1, -32'sd1));
		// A deep entry, then a clear: afterwards a shallow record is taken.
		send_item(make_item(FUNC_RECORD, KEY_ZERO, 6'd40, 32'sd5, BOUND_EXACT, '0, '0));
		send_item(make_item(FUNC_CLEAR, '0, '0, '0, BOUND_EXACT, '0, '0));
		send_item(make_item(FUNC_PROBE, KEY_ALIAS, 6'd0, '0, BOUND_EXACT, SCORE_MIN, SCORE_MIN));
		send_item(make_item(FUNC_RECORD, KEY_ZERO, 6'd3, -32'sd5, BOUND_EXACT, '0, '0));
		send_item(make_item(FUNC_PROBE, KEY_ZERO, 6'd3, '0, BOUND_EXACT, '0, '0));
		wait_until_drained();

		// Random part, phase by phase, each phase closed by a full drain.
		send_random(130, 0, 0);
		wait_until_drained();
		send_random(90, 81, 0);
		wait_until_drained();
		send_random(90, 0, 81);
		wait_until_drained();

		// Long hold on the result side while items keep being offered.
		hold_request = 1'b1;
		send_random(30, 0, 0);
		while (!hold_done)
			@(posedge clk);
		hold_request = 1'b0;
		wait_until_drained();

		send_random(160, 12, 12);
		recv_stall_pct = 0;
		wait_until_drained();

		// Leave time for any stray result to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items (%0d clears) and checked %0d results.",
			items_sent, clears_sent, results_seen);
		$display("Of these, %0d probes hit and %0d records were stored.",
			probe_hits, records_written);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
